// ----- design/fcte_pkg.sv -----
package fcte_pkg;

  localparam int WORD_W            = 32;
  localparam int ENTRIES_W         = 13;
  localparam int LOWEST_W          = 12;
  localparam int CFG_IDX_W         = 2;
  localparam int OP_W              = 2;
  localparam int STATUS_W          = 3;
  localparam int TABLE_ENTRIES_DEF = 4096;

  localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = ENTRIES_W'(4096);
  localparam logic [LOWEST_W-1:0]  LOWEST_RESET  = LOWEST_W'(2);
  localparam logic [WORD_W-1:0]    END_RESET     = 32'h0FFF_FFFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END     = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_FIND  = 2'd2,
    OP_WALK  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_FREE  = 3'd1,
    ST_BROKEN   = 3'd2,
    ST_RANGE    = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_t;

endpackage

// ----- design/fcte_ram.sv -----
module fcte_ram
  #(parameter int WIDTH = 32,
    parameter int DEPTH = 4096)
  (input  logic                     clk,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/fat_cluster_table_engine.sv -----
// Cluster link table engine: keeps a table of 32-bit cluster links in one RAM
// and answers one item at a time: write an entry, read an entry, search upward
// for the first empty entry, or follow a chain to its last cluster. The RAM has
// one registered read port, and every search step or chain hop is one read: a
// write or an out-of-range item goes straight to the done state, a read takes
// one lookup, and a search or walk reads each entry it visits (up to the active
// limit). A new item is taken only once the last result has left the done
// state. The result goes to an output register, so a new item can be accepted
// while the previous result still waits. The table is not cleared at reset;
// every entry must be written before it is read, searched or walked.
module fat_cluster_table_engine
  import fcte_pkg::*;
  #(parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF)
  (input  logic                 clk,
   input  logic                 rst,
   input  logic                 cfg_write,
   input  logic [CFG_IDX_W-1:0] cfg_index,
   input  logic [WORD_W-1:0]    cfg_data,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  logic [OP_W-1:0]      operation,
   input  logic [WORD_W-1:0]    cluster,
   input  logic [WORD_W-1:0]    entry_value,
   output logic                 out_valid,
   input  logic                 out_stall,
   output logic [WORD_W-1:0]    result_cluster,
   output logic [STATUS_W-1:0]  status);

  localparam int AW    = $clog2(TABLE_ENTRIES);
  localparam int LIM_W = (AW + 1 > ENTRIES_W) ? AW + 1 : ENTRIES_W;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_DONE} state_t;

  state_t              state;
  logic [ENTRIES_W-1:0] entries_in_use;
  logic [LOWEST_W-1:0]  lowest_data_cluster;
  logic [WORD_W-1:0]    end_marker;

  op_t                 op;
  logic [AW-1:0]       cur;
  logic [LIM_W-1:0]    visits;
  logic [WORD_W-1:0]   pend_value;
  status_t             pend_status;

  logic [LIM_W-1:0]    limit;
  logic                accept;
  logic                out_free;

  logic                ram_we;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [WORD_W-1:0]   link;

  logic [LIM_W-1:0]    cur_inc;
  logic [LIM_W-1:0]    visits_inc;
  logic                fin;
  logic [WORD_W-1:0]   fin_value;
  status_t             fin_status;
  logic [AW-1:0]       cur_next;

  assign limit = (LIM_W'(entries_in_use) < LIM_W'(TABLE_ENTRIES)) ?
                 LIM_W'(entries_in_use) : LIM_W'(TABLE_ENTRIES);

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign cur_inc    = LIM_W'(cur) + LIM_W'(1);
  assign visits_inc = visits + LIM_W'(1);

  fcte_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cluster[AW-1:0]),
    .wdata (entry_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (link)
  );

  // Request side: writes and first reads come straight from the input item;
  // further reads come from the lookup step.
  always_comb begin
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = cluster[AW-1:0];
    fin        = 1'b0;
    fin_value  = '0;
    fin_status = ST_OK;
    cur_next   = cur;
    if (accept && cluster < WORD_W'(limit)) begin
      if (op_t'(operation) == OP_WRITE) begin
        ram_we = 1'b1;
      end else begin
        ram_re = 1'b1;
      end
    end
    if (state == S_LOOK) begin
      unique case (op)
        OP_READ: begin
          fin       = 1'b1;
          fin_value = link;
        end
        OP_FIND: begin
          if (link == '0) begin
            fin       = 1'b1;
            fin_value = WORD_W'(cur);
          end else if (cur_inc >= limit) begin
            fin        = 1'b1;
            fin_status = ST_NO_FREE;
          end else begin
            ram_re    = 1'b1;
            cur_next  = cur_inc[AW-1:0];
            ram_raddr = cur_next;
          end
        end
        OP_WALK: begin
          if (link == end_marker) begin
            fin       = 1'b1;
            fin_value = WORD_W'(cur);
          end else if (link >= WORD_W'(lowest_data_cluster) && link < end_marker) begin
            if (link >= WORD_W'(limit)) begin
              fin        = 1'b1;
              fin_status = ST_RANGE;
            end else if (visits_inc >= limit) begin
              // Visited as many entries as the table holds: a cycle.
              fin        = 1'b1;
              fin_status = ST_TOO_LONG;
            end else begin
              ram_re    = 1'b1;
              cur_next  = link[AW-1:0];
              ram_raddr = cur_next;
            end
          end else if (link == '0) begin
            fin       = 1'b1;
            fin_value = WORD_W'(cur);
          end else begin
            fin        = 1'b1;
            fin_status = ST_BROKEN;
          end
        end
        default: begin
          fin = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      out_valid           <= 1'b0;
      entries_in_use      <= ENTRIES_RESET;
      lowest_data_cluster <= LOWEST_RESET;
      end_marker          <= END_RESET;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_ENTRIES: entries_in_use      <= cfg_data[ENTRIES_W-1:0];
          CFG_LOWEST:  lowest_data_cluster <= cfg_data[LOWEST_W-1:0];
          CFG_END:     end_marker          <= cfg_data;
          default: ;
        endcase
      end

      // In the done state a taken result is replaced by the next one below.
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op     <= op_t'(operation);
            cur    <= cluster[AW-1:0];
            visits <= '0;
            if (cluster >= WORD_W'(limit)) begin
              pend_value  <= '0;
              pend_status <= ST_RANGE;
              state       <= S_DONE;
            end else if (op_t'(operation) == OP_WRITE) begin
              pend_value  <= '0;
              pend_status <= ST_OK;
              state       <= S_DONE;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (fin) begin
            pend_value  <= fin_value;
            pend_status <= fin_status;
            state       <= S_DONE;
          end else begin
            cur    <= cur_next;
            visits <= visits_inc;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            result_cluster <= pend_value;
            status         <= pend_status;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/fcte_checker.sv -----
module fcte_checker
  import fcte_pkg::*;
  (input logic                 clk,
   input logic                 rst,
   input logic                 cfg_write,
   input logic [CFG_IDX_W-1:0] cfg_index,
   input logic [WORD_W-1:0]    cfg_data,
   input logic                 in_valid,
   input logic                 in_stall,
   input logic [OP_W-1:0]      operation,
   input logic [WORD_W-1:0]    cluster,
   input logic [WORD_W-1:0]    entry_value,
   input logic                 out_valid,
   input logic                 out_stall,
   input logic [WORD_W-1:0]    result_cluster,
   input logic [STATUS_W-1:0]  status);

  // A held result must not change under the consumer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(result_cluster) && $stable(status))
    else $error("result changed while stalled");

  // The engine works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in progress");

  // A new result is published only as the engine goes back to idle.
  a_result_at_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result published while still busy");

  // Every failure reports a zero cluster.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> result_cluster == '0)
    else $error("failure with nonzero cluster");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_TOO_LONG)
    else $error("status code out of range");

endmodule

bind fat_cluster_table_engine fcte_checker u_fcte_checker (.*);

// ----- verif/fat_cluster_table_engine_checker.sv -----
`timescale 1ns / 1ps

module fat_cluster_table_engine_checker
  import fcte_pkg::*;
  #(parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF)
  (input  logic                 clk,
   input  logic                 rst,
   input  logic                 cfg_write,
   input  logic [CFG_IDX_W-1:0] cfg_index,
   input  logic [WORD_W-1:0]    cfg_data,
   input  logic                 in_valid,
   input  logic                 in_stall,
   input  logic [OP_W-1:0]      operation,
   input  logic [WORD_W-1:0]    cluster,
   input  logic [WORD_W-1:0]    entry_value,
   input  logic                 out_valid,
   input  logic                 out_stall,
   input  logic [WORD_W-1:0]    result_cluster,
   input  logic [STATUS_W-1:0]  status,
   output int                   pending_results,
   output int                   mismatches);

  typedef struct packed {
    logic [WORD_W-1:0] cluster;
    status_t           status;
  } link_answer_t;

  logic [WORD_W-1:0]    link_mirror [TABLE_ENTRIES];
  logic [ENTRIES_W-1:0] entries_in_use;
  logic [LOWEST_W-1:0]  lowest_data;
  logic [WORD_W-1:0]    end_marker;
  link_answer_t         expected_answers [$];

  initial begin
    mismatches = 0;
    pending_results = 0;
  end

  function automatic int unsigned active_limit();
    return (entries_in_use < TABLE_ENTRIES) ? int'(entries_in_use) : TABLE_ENTRIES;
  endfunction

  task automatic answer_item(input op_t op, input logic [WORD_W-1:0] cl,
                             input logic [WORD_W-1:0] val, output link_answer_t ans);
    int unsigned       limit;
    int unsigned       idx;
    int unsigned       visits;
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] link;
    bit                done;
    limit = active_limit();
    ans.cluster = '0;
    ans.status = ST_OK;
    done = 1'b0;
    if (cl >= limit) begin
      ans.status = ST_RANGE;
    end else begin
      case (op)
        OP_WRITE: link_mirror[cl] = val;
        OP_READ:  ans.cluster = link_mirror[cl];
        OP_FIND: begin
          ans.status = ST_NO_FREE;
          for (idx = cl; idx < limit && !done; idx++) begin
            if (link_mirror[idx] == '0) begin
              ans.cluster = idx;
              ans.status = ST_OK;
              done = 1'b1;
            end
          end
        end
        OP_WALK: begin
          // The end marker is checked before the link range, and a zero
          // entry only ends the walk when it is not a followable link.
          cur = cl;
          ans.status = ST_TOO_LONG;
          visits = 0;
          while (!done && visits < limit) begin
            link = link_mirror[cur];
            if (link == end_marker) begin
              ans.cluster = cur;
              ans.status = ST_OK;
              done = 1'b1;
            end else if (link >= lowest_data && link < end_marker) begin
              if (link >= limit) begin
                ans.status = ST_RANGE;
                done = 1'b1;
              end else begin
                cur = link;
              end
            end else if (link == '0) begin
              ans.cluster = cur;
              ans.status = ST_OK;
              done = 1'b1;
            end else begin
              ans.status = ST_BROKEN;
              done = 1'b1;
            end
            visits++;
          end
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    link_answer_t want;
    if (rst) begin
      entries_in_use = ENTRIES_RESET;
      lowest_data = LOWEST_RESET;
      end_marker = END_RESET;
      expected_answers.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ENTRIES: entries_in_use = cfg_data[ENTRIES_W-1:0];
          CFG_LOWEST:  lowest_data = cfg_data[LOWEST_W-1:0];
          CFG_END:     end_marker = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        answer_item(op_t'(operation), cluster, entry_value, want);
        expected_answers.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("result with no item waiting", result_cluster, '0);
        end else begin
          want = expected_answers.pop_front();
          if (result_cluster !== want.cluster)
            report_mismatch("result_cluster", result_cluster, want.cluster);
          if (status !== want.status)
            report_mismatch("status", WORD_W'(status), WORD_W'(want.status));
        end
      end
    end
    pending_results <= expected_answers.size();
  end

endmodule

// ----- verif/fat_cluster_table_engine_tb.sv -----
`timescale 1ns / 1ps

module fat_cluster_table_engine_tb;
  import fcte_pkg::*;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int LOAD_ENTRIES = 136;
  localparam int REACH_MAX    = LOAD_ENTRIES - 4;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ENTRIES;
  logic [WORD_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      operation = OP_READ;
  logic [WORD_W-1:0]    cluster = '0;
  logic [WORD_W-1:0]    entry_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WORD_W-1:0]    result_cluster;
  logic [STATUS_W-1:0]  status;

  int pending_results;
  int mismatches;
  int cycle_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  logic hold_armed = 1'b0;

  // Limits of the current setting, used to aim the random items. Random
  // items stay below phase_reach, so only the loaded low part of the table
  // is ever read; the top loaded entry stays empty and ends every search.
  int unsigned       phase_limit = TABLE_ENTRIES_DEF;
  int unsigned       phase_reach = REACH_MAX;
  int unsigned       phase_lowest = LOWEST_RESET;
  logic [WORD_W-1:0] phase_end = END_RESET;

  fat_cluster_table_engine uut (.*);

  fat_cluster_table_engine_checker answer_check (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: stall patterns that change every so often, plus one long hold.
  initial begin
    int mode;
    int mode_left;
    bit hold_done;
    bit toggle;
    mode = 0;
    mode_left = 0;
    hold_done = 1'b0;
    toggle = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        toggle = ~toggle;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= toggle;
        endcase
      end
    end
  end

  task automatic send_item(input op_t op, input logic [WORD_W-1:0] cl,
                           input logic [WORD_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(40, 150);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 10);
        gap = $urandom_range(0, 6);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    operation <= op;
    cluster <= cl;
    entry_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Upper bits beyond each register's width carry noise that must be ignored.
  task automatic set_config(input int unsigned entries, input int unsigned lowest,
                            input logic [WORD_W-1:0] end_value);
    logic [WORD_W-1:0] word;
    word = $urandom();
    word[ENTRIES_W-1:0] = ENTRIES_W'(entries);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ENTRIES;
    cfg_data <= word;
    @(posedge clk);
    word = $urandom();
    word[LOWEST_W-1:0] = LOWEST_W'(lowest);
    cfg_index <= CFG_LOWEST;
    cfg_data <= word;
    @(posedge clk);
    cfg_index <= CFG_END;
    cfg_data <= end_value;
    @(posedge clk);
    cfg_write <= 1'b0;
    phase_limit = (entries < TABLE_ENTRIES_DEF) ? entries : TABLE_ENTRIES_DEF;
    phase_reach = (phase_limit < REACH_MAX) ? phase_limit : REACH_MAX;
    phase_lowest = lowest;
    phase_end = end_value;
  endtask

  // Large random values sit above every possible limit.
  function automatic logic [WORD_W-1:0] pick_cluster();
    if (phase_limit == 0 || $urandom_range(0, 19) == 0)
      return $urandom() | 32'h0001_0000;
    if ($urandom_range(0, 19) == 0)
      return phase_limit + $urandom_range(0, 2);
    return $urandom_range(0, phase_reach - 1);
  endfunction

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1: return phase_end;
      2, 3, 4: begin
        if (phase_lowest < phase_reach)
          return $urandom_range(phase_lowest, phase_reach - 1);
        return $urandom_range(0, 40);
      end
      5: return '0;
      6: return $urandom() | 32'h0001_0000;
      7: return phase_end + 1;
      8: return $urandom_range(0, phase_lowest);
      default: return $urandom_range(0, phase_reach + 2);
    endcase
  endfunction

  // A well-formed chain ending mostly at the end marker, then queries on it.
  task automatic chain_sequence();
    logic [WORD_W-1:0] nodes [8];
    logic [WORD_W-1:0] tail;
    int                hops;
    hops = $urandom_range(1, 6);
    for (int i = 0; i <= hops; i++)
      nodes[i] = $urandom_range(phase_lowest, phase_reach - 1);
    for (int i = 0; i < hops; i++)
      send_item(OP_WRITE, nodes[i], nodes[i + 1]);
    case ($urandom_range(0, 9))
      0: tail = nodes[0];
      1: tail = '0;
      2: tail = pick_value();
      default: tail = phase_end;
    endcase
    send_item(OP_WRITE, nodes[hops], tail);
    send_item(OP_WALK, nodes[$urandom_range(0, hops)], $urandom());
    case ($urandom_range(0, 3))
      0: send_item(OP_READ, nodes[$urandom_range(0, hops)], $urandom());
      1: send_item(OP_FIND, nodes[$urandom_range(0, hops)], $urandom());
      default: ;
    endcase
  endtask

  task automatic run_phase(input int unsigned entries, input int unsigned lowest,
                           input logic [WORD_W-1:0] end_value, input int count);
    int first;
    set_config(entries, lowest, end_value);
    first = items_sent;
    while (items_sent - first < count) begin
      if (phase_lowest < phase_reach && $urandom_range(0, 9) < 6)
        chain_sequence();
      else if ($urandom_range(0, 2) == 0)
        send_item(OP_WRITE, pick_cluster(), pick_value());
      else
        send_item(op_t'($urandom_range(0, 3)), pick_cluster(), pick_value());
      if ($urandom_range(0, 99) == 0)
        wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    int unsigned entries;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Out of range with the reset setting touches no entry.
    send_item(OP_READ, 32'hFFFF_FFFF, '0);
    send_item(OP_WALK, 32'd4096, '0);

    // Load the low part of the table; nothing above it is read before written.
    for (int i = 0; i < LOAD_ENTRIES; i++)
      send_item(OP_WRITE, i, '0);

    send_item(OP_WRITE, 32'd2, 32'd3);
    send_item(OP_WRITE, 32'd3, 32'd4);
    send_item(OP_WRITE, 32'd4, END_RESET);
    send_item(OP_WALK, 32'd2, '0);
    send_item(OP_READ, 32'd3, '0);
    send_item(OP_FIND, 32'd2, '0);
    send_item(OP_FIND, 32'd0, '0);
    // Links below the lowest data cluster, past the table and above the end marker.
    send_item(OP_WRITE, 32'd10, 32'd1);
    send_item(OP_WALK, 32'd10, '0);
    send_item(OP_WRITE, 32'd11, 32'd5000);
    send_item(OP_WALK, 32'd11, '0);
    send_item(OP_WRITE, 32'd12, 32'hFFFF_FFFF);
    send_item(OP_WALK, 32'd12, '0);
    // A walk that ends on an empty entry.
    send_item(OP_WRITE, 32'd30, 32'd31);
    send_item(OP_WALK, 32'd30, '0);
    // A two-entry loop runs into the walk length guard.
    send_item(OP_WRITE, 32'd20, 32'd21);
    send_item(OP_WRITE, 32'd21, 32'd20);
    send_item(OP_WALK, 32'd20, '0);
    // No empty entry from the top index up.
    send_item(OP_WRITE, 32'd4095, 32'hFFFF_FFFF);
    send_item(OP_FIND, 32'd4095, '0);
    send_item(OP_READ, 32'd4095, '0);
    send_item(OP_WRITE, 32'd4096, 32'd7);
    send_item(OP_WRITE, 32'hFFFF_FFFF, 32'd9);
    send_item(OP_READ, 32'd0, '0);
    wait_drained();

    hold_armed <= 1'b1;
    run_phase(16, 2, END_RESET, 300);
    run_phase(40, 0, 32'hFFFF_FFFF, 250);
    run_phase(64, 4095, 32'd5, 150);
    run_phase(1, 2, 32'd0, 60);
    run_phase(0, 2, END_RESET, 30);
    run_phase(8191, 2, END_RESET, 50);
    run_phase(4096, 100, 32'd3000, 40);
    run_phase(24, 3, 32'd20, 300);
    for (int p = 0; p < 3; p++) begin
      entries = $urandom_range(2, 128);
      case ($urandom_range(0, 2))
        0: run_phase(entries, $urandom_range(0, entries), END_RESET, 100);
        1: run_phase(entries, $urandom_range(0, entries), $urandom_range(0, entries + 4), 100);
        default: run_phase(entries, $urandom_range(0, entries), $urandom(), 100);
      endcase
    end

    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
